// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define AST_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never failed");
`else
`define AST_CLK(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/see_pkg.sv -----
// Shared types and constants for the stack expression evaluator.
// No dependencies.
`default_nettype none
package see_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned DefStackDepth = 32;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;
endpackage
`default_nettype wire

// ----- hw/rtl/see_alu.sv -----
// Bit-serial 64-bit arithmetic unit: add/sub/mul/div, one bit per cycle.
// Depends on see_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module see_alu
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      res
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;
    state_t      state_reg;
    logic [6:0]  cnt_reg;
    logic [1:0]  op_reg;
    logic [63:0] x_reg;    // add/sub: a bits; mul: b multiplier; div: dividend/quotient
    logic [63:0] y_reg;    // add/sub: b bits; mul: shifting multiplicand; div: divisor mag
    logic [63:0] acc_reg;  // add: result; mul: product; div: remainder
    logic        carry_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [63:0] ma, mb;
    logic [64:0] rem_sh, rem_sub;
    logic        fa;
    always_comb
    begin
        ma = a[63] ? (64'd0 - a) : a;
        mb = b[63] ? (64'd0 - b) : b;
        rem_sh  = {acc_reg[63:0], x_reg[63]};
        rem_sub = rem_sh - {1'b0, y_reg};
        fa = x_reg[0] ^ (y_reg[0] ^ (op_reg == see_pkg::OP_SUB)) ^ carry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        carry_reg <= (op == see_pkg::OP_SUB);
                        neg_reg   <= a[63] ^ b[63];
                        if (op == see_pkg::OP_DIV)
                        begin
                            x_reg <= ma;
                            y_reg <= mb;
                        end
                        else if (op == see_pkg::OP_MUL)
                        begin
                            x_reg <= b;
                            y_reg <= a;
                        end
                        else
                        begin
                            x_reg <= a;
                            y_reg <= b;
                        end
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    case (op_reg)
                        see_pkg::OP_MUL:
                        begin
                            if (x_reg[0])
                                acc_reg[63:0] <= acc_reg[63:0] + y_reg;
                            x_reg <= x_reg >> 1;
                            y_reg <= y_reg << 1;
                        end
                        see_pkg::OP_DIV:
                        begin
                            // remainder stays below the divisor, so 64 bits hold it
                            if (!rem_sub[64])
                            begin
                                acc_reg <= rem_sub[63:0];
                                x_reg   <= {x_reg[62:0], 1'b1};
                            end
                            else
                            begin
                                acc_reg <= rem_sh[63:0];
                                x_reg   <= {x_reg[62:0], 1'b0};
                            end
                        end
                        default:
                        begin
                            carry_reg <= (x_reg[0] & (y_reg[0] ^ (op_reg == see_pkg::OP_SUB)))
                                | (carry_reg & (x_reg[0] ^ y_reg[0]
                                ^ (op_reg == see_pkg::OP_SUB)));
                            acc_reg[63:0] <= {fa, acc_reg[63:1]};
                            x_reg <= x_reg >> 1;
                            y_reg <= y_reg >> 1;
                        end
                    endcase
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    if (op_reg == see_pkg::OP_DIV && neg_reg)
                        x_reg <= 64'd0 - x_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == see_pkg::OP_DIV) ? x_reg : acc_reg[63:0];

    `AST_CLK(a_done_after_fix, clk, rst_n, done_reg |-> $past(state_reg == S_FIX))
    `AST_NEVER(a_no_start_busy, clk, rst_n, start && state_reg != S_IDLE)
    `AST_CLK(a_cnt_range, clk, rst_n, state_reg == S_RUN |-> cnt_reg < 7'd64)
endmodule
`default_nettype wire

// ----- hw/rtl/stack_expression_evaluator_top.sv -----
// Top level of the stack expression evaluator: token stream in, result stream out.
// Depends on see_pkg, see_alu and assert_macros.svh.
// An operand token is pushed in the beat that accepts it. An operator token runs from its
// beat to the next accepted beat through two stack reads, an operand latch, the ALU start,
// the bit-serial ALU run, a sign fix and the done/write-back step; a divide by zero ends
// in the ALU-start step without starting the ALU. The last token adds a top-of-stack read
// and the result beat load, held back while an earlier result beat is still waiting. The stack has
// one write and one read port; its contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module stack_expression_evaluator_top #(
    parameter int unsigned STACK_DEPTH = see_pkg::DefStackDepth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,      // notation
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // operand_value[31:0], operator_code[33:32], 0
    input  wire logic        s_axis_tuser,   // req_type
    input  wire logic        s_axis_tlast,   // last_token
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // result_value[63:0], status[65:64], 0
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_ALU, S_WAIT, S_TOP, S_TOPD, S_OUT}
        state_t;
    state_t state_reg;

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rd_reg, second_reg, res_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]  err_reg, st_reg, op_reg;
    logic        last_reg, nota_reg, alu_start_reg, ovalid_reg;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0] mem_wd;
    logic [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    // from S_ALU on: second_reg holds the entry below the top, rd_reg the top
    assign alu_a = nota_reg ? rd_reg : second_reg;
    assign alu_b = nota_reg ? second_reg : rd_reg;

    see_alu u_alu (
        .clk(clk), .rst_n(rst_n), .start(alu_start_reg), .op(op_reg),
        .a(alu_a), .b(alu_b), .done(alu_done), .res(alu_res)
    );

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = AW'(cnt_reg);
        mem_wd = {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
        mem_ra = AW'(cnt_reg - CW'(1));
        if (state_reg == S_IDLE)
            mem_we = accept && !s_axis_tuser && err_reg == see_pkg::ST_OK && cnt_reg != FULL;
        else if (state_reg == S_RD1)
            mem_ra = AW'(cnt_reg - CW'(2));
        else if (state_reg == S_WAIT)
        begin
            mem_we = alu_done;
            mem_wa = AW'(cnt_reg - CW'(2));
            mem_wd = alu_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= see_pkg::ST_OK;
            nota_reg      <= 1'b0;
            alu_start_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                nota_reg <= cfg_wdata;
            // S_TOPD reloads the result beat itself
            if (ovalid_reg && m_axis_tready && state_reg != S_TOPD)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= s_axis_tlast;
                        op_reg   <= s_axis_tdata[33:32];
                        if (err_reg != see_pkg::ST_OK)
                            state_reg <= s_axis_tlast ? S_TOP : S_IDLE;
                        else if (!s_axis_tuser)
                        begin
                            if (cnt_reg == FULL)
                                err_reg <= see_pkg::ST_OVERFLOW;
                            else
                                cnt_reg <= cnt_reg + CW'(1);
                            state_reg <= s_axis_tlast ? S_TOP : S_IDLE;
                        end
                        else if (cnt_reg < CW'(2))
                        begin
                            err_reg   <= see_pkg::ST_UNDERFLOW;
                            state_reg <= s_axis_tlast ? S_TOP : S_IDLE;
                        end
                        else
                            state_reg <= S_RD1;
                    end
                end
                S_RD1: state_reg <= S_RD2;
                S_RD2:
                begin
                    second_reg <= rd_reg;
                    state_reg  <= S_ALU;
                end
                S_ALU:
                begin
                    if (op_reg == see_pkg::OP_DIV && alu_b == '0)
                    begin
                        err_reg   <= see_pkg::ST_DIVZERO;
                        state_reg <= last_reg ? S_TOP : S_IDLE;
                    end
                    else
                    begin
                        alu_start_reg <= 1'b1;
                        state_reg     <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    alu_start_reg <= 1'b0;
                    if (alu_done)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= last_reg ? S_TOP : S_IDLE;
                    end
                end
                S_TOP: state_reg <= S_TOPD;
                S_TOPD:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        if (err_reg != see_pkg::ST_OK)
                        begin
                            st_reg  <= err_reg;
                            res_reg <= '0;
                        end
                        else if (cnt_reg == '0)
                        begin
                            st_reg  <= see_pkg::ST_UNDERFLOW;
                            res_reg <= '0;
                        end
                        else
                        begin
                            st_reg  <= see_pkg::ST_OK;
                            res_reg <= rd_reg;
                        end
                        ovalid_reg <= 1'b1;
                        cnt_reg    <= '0;
                        err_reg    <= see_pkg::ST_OK;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, st_reg, res_reg};

    `AST_CLK(a_cnt_bound, clk, rst_n, cnt_reg <= FULL)
    `AST_CLK(a_err_zero_res, clk, rst_n, ovalid_reg && st_reg != see_pkg::ST_OK |-> res_reg == '0)
    `AST_NEVER(a_we_err, clk, rst_n, mem_we && state_reg == S_IDLE && err_reg != see_pkg::ST_OK)
endmodule
`default_nettype wire
